// ===== design/shp_pkg.sv =====
package shp_pkg;

    // Register map, word index of the APB byte address
    localparam logic [2:0] REG_STEP_PERIOD = 3'd0;
    localparam logic [2:0] REG_MOVE_COUNT  = 3'd1;
    localparam logic [2:0] REG_DEBOUNCE    = 3'd2;
    localparam logic [2:0] REG_BACKOFF     = 3'd3;
    localparam logic [2:0] REG_SETTLE      = 3'd4;

    localparam int unsigned ADDR_W = 5;

    // Reset values of the configuration registers
    localparam logic [14:0] RST_STEP_PERIOD = 15'd1000;
    localparam logic [31:0] RST_MOVE_COUNT  = 32'd0;
    localparam logic [31:0] RST_DEBOUNCE    = 32'd50000;
    localparam logic [15:0] RST_BACKOFF     = 16'd15000;
    localparam logic [15:0] RST_SETTLE      = 16'd20000;

    // Commands
    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_UP     = 2'd1;
    localparam logic [1:0] CMD_DOWN   = 2'd2;
    localparam logic [1:0] CMD_RETURN = 2'd3;

    // Positions
    localparam logic [1:0] POS_MIDDLE = 2'd0;
    localparam logic [1:0] POS_UP     = 2'd1;
    localparam logic [1:0] POS_DOWN   = 2'd2;

    // Direction pin levels
    localparam logic DIR_UP   = 1'b0;
    localparam logic DIR_DOWN = 1'b1;

    typedef enum logic [2:0] {
        PH_SEEK1   = 3'd0,
        PH_BACKOFF = 3'd1,
        PH_SETTLE  = 3'd2,
        PH_FINISH  = 3'd3,
        PH_DONE    = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MOD  = 2'd1,
        ST_EXEC = 2'd2
    } t_state;

    typedef struct packed {
        logic [14:0] step_period;
        logic [31:0] move_count;
        logic [31:0] debounce;
        logic [15:0] backoff;
        logic [15:0] settle;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture input beat, start the modulo
        logic exec;   // commit one control pass
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic mod_done;
    } t_dp_stat;

endpackage

// ===== design/stepper_homing_and_position_control_unit.sv =====
// Stepper homing and position control.
// Input channel (i_in_valid / o_in_ready) carries one control-loop pass per
// beat: microsecond time, raw active-low limit button and command. Output
// channel (o_out_valid / i_out_ready) returns one beat per pass with the
// step and direction levels, move idle and homing done flags and position.
// A pass runs the bit-serial remainder of time by the step period, then the
// controller sees the remainder finish and commits the pass.
// One pass is in flight at a time and the next beat is taken the cycle after
// the commit, so a new beat is not accepted before the last pass commits.
// Configuration sits on the APB port, registers at byte addresses 0, 4, 8,
// 12 and 16; write it only while the block is idle.
// Reset returns the homing sequence to its start and the registers to their
// defaults. If the receiver stalls, the result holds on the output and the
// next pass is accepted and computed, waiting to commit until the pending
// beat is taken.
module stepper_homing_and_position_control_unit
    import shp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [31:0]       i_now_us,
    input  logic              i_button_level,
    input  logic [1:0]        i_command,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_step_level,
    output logic              o_dir_level,
    output logic              o_move_idle,
    output logic              o_homing_done,
    output logic [1:0]        o_position,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg     w_cfg;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    shp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    shp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    shp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_now_us       (i_now_us),
        .i_button_level (i_button_level),
        .i_command      (i_command),
        .o_step_level   (o_step_level),
        .o_dir_level    (o_dir_level),
        .o_move_idle    (o_move_idle),
        .o_homing_done  (o_homing_done),
        .o_position     (o_position)
    );

endmodule

// ===== design/shp_regs.sv =====
module shp_regs
    import shp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output t_cfg                o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[ADDR_W-1:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_period <= RST_STEP_PERIOD;
            r_cfg.move_count  <= RST_MOVE_COUNT;
            r_cfg.debounce    <= RST_DEBOUNCE;
            r_cfg.backoff     <= RST_BACKOFF;
            r_cfg.settle      <= RST_SETTLE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_STEP_PERIOD: r_cfg.step_period <= pwdata[14:0];
                REG_MOVE_COUNT:  r_cfg.move_count  <= pwdata;
                REG_DEBOUNCE:    r_cfg.debounce    <= pwdata;
                REG_BACKOFF:     r_cfg.backoff     <= pwdata[15:0];
                REG_SETTLE:      r_cfg.settle      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (w_idx)
            REG_STEP_PERIOD: prdata = {17'd0, r_cfg.step_period};
            REG_MOVE_COUNT:  prdata = r_cfg.move_count;
            REG_DEBOUNCE:    prdata = r_cfg.debounce;
            REG_BACKOFF:     prdata = {16'd0, r_cfg.backoff};
            REG_SETTLE:      prdata = {16'd0, r_cfg.settle};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/shp_mod.sv =====
module shp_mod
    import shp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [14:0] i_divisor,
    output logic [14:0] o_rem,
    output logic        o_done
);

    // Restoring remainder, one dividend bit per cycle
    logic [31:0] r_dvd;
    logic [14:0] r_rem;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [15:0] w_shift;
    logic [15:0] w_diff;
    logic [14:0] n_rem;

    assign w_shift = {r_rem, r_dvd[31]};
    assign w_diff  = w_shift - {1'b0, i_divisor};
    assign n_rem   = (w_shift >= {1'b0, i_divisor}) ? w_diff[14:0] : w_shift[14:0];

    // Control of the iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Remainder and dividend shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= 15'd0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

// ===== design/shp_dp.sv =====
module shp_dp
    import shp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic [31:0] i_now_us,
    input  logic        i_button_level,
    input  logic [1:0]  i_command,
    output logic        o_step_level,
    output logic        o_dir_level,
    output logic        o_move_idle,
    output logic        o_homing_done,
    output logic [1:0]  o_position
);

    // Captured input beat
    logic [31:0] r_t;
    logic        r_lvl;
    logic [1:0]  r_cmd;

    // Control state
    t_phase      r_phase,     n_phase;
    logic [15:0] r_hcnt,      n_hcnt;
    logic [31:0] r_mcnt,      n_mcnt;
    logic [1:0]  r_pos,       n_pos;
    logic [31:0] r_release,   n_release;
    logic        r_step,      n_step;
    logic        r_dir,       n_dir;
    logic        r_done,      n_done;

    logic [14:0] w_rem;
    logic        w_mod_done;
    logic        w_wave;
    logic        w_press;
    logic [31:0] w_elapsed;
    logic        w_move;
    logic        w_move_dir;
    logic [1:0]  w_move_pos;

    shp_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.load),
        .i_dividend (i_now_us),
        .i_divisor  (i_cfg.step_period),
        .o_rem      (w_rem),
        .o_done     (w_mod_done)
    );

    assign o_stat.mod_done = w_mod_done;

    // Step wave level from the remainder
    assign w_wave = (i_cfg.step_period == 15'd0) ? 1'b0
                  : (w_rem > {1'b0, i_cfg.step_period[14:1]});

    // Debounced press, valid when the pass samples the button
    assign w_elapsed = r_t - r_release;
    assign w_press   = !r_lvl && (w_elapsed > i_cfg.debounce);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t   <= i_now_us;
            r_lvl <= i_button_level;
            r_cmd <= i_command;
        end
    end

    // Move selection after homing
    always_comb begin
        w_move     = 1'b0;
        w_move_dir = DIR_UP;
        w_move_pos = POS_MIDDLE;
        priority if (r_cmd == CMD_UP && r_pos != POS_UP) begin
            w_move     = 1'b1;
            w_move_dir = DIR_UP;
            w_move_pos = POS_UP;
        end else if (r_cmd == CMD_DOWN && r_pos != POS_DOWN) begin
            w_move     = 1'b1;
            w_move_dir = DIR_DOWN;
            w_move_pos = POS_DOWN;
        end else if (r_cmd == CMD_RETURN && r_pos == POS_UP) begin
            w_move     = 1'b1;
            w_move_dir = DIR_DOWN;
            w_move_pos = POS_MIDDLE;
        end else if (r_cmd == CMD_RETURN && r_pos == POS_DOWN) begin
            w_move     = 1'b1;
            w_move_dir = DIR_UP;
            w_move_pos = POS_MIDDLE;
        end else begin
            w_move = 1'b0;
        end
    end

    // Next state of one control pass
    always_comb begin
        n_phase   = r_phase;
        n_hcnt    = r_hcnt;
        n_mcnt    = r_mcnt;
        n_pos     = r_pos;
        n_release = r_release;
        n_step    = r_step;
        n_dir     = r_dir;
        n_done    = r_done;
        unique case (r_phase)
            PH_SEEK1: begin
                n_dir  = DIR_DOWN;
                n_step = w_wave;
                if (r_lvl) begin
                    n_release = r_t;
                end else if (w_press) begin
                    n_phase = PH_BACKOFF;
                end
            end
            PH_BACKOFF: begin
                if (r_hcnt < i_cfg.backoff) begin
                    n_dir  = DIR_UP;
                    n_step = w_wave;
                    n_hcnt = r_hcnt + 16'd1;
                end else begin
                    n_dir  = DIR_DOWN;
                    n_step = w_wave;
                    if (r_lvl) begin
                        n_release = r_t;
                    end else if (w_press) begin
                        n_phase = PH_SETTLE;
                        n_hcnt  = 16'd0;
                    end
                end
            end
            PH_SETTLE: begin
                if (r_hcnt < i_cfg.settle) begin
                    n_dir  = DIR_UP;
                    n_step = w_wave;
                    n_hcnt = r_hcnt + 16'd1;
                end else begin
                    n_phase = PH_FINISH;
                end
            end
            PH_FINISH: begin
                n_phase = PH_DONE;
                n_pos   = POS_MIDDLE;
                n_hcnt  = 16'd0;
            end
            PH_DONE: begin
                if (w_move) begin
                    if (r_mcnt < i_cfg.move_count) begin
                        n_done = 1'b0;
                        n_dir  = w_move_dir;
                        n_step = w_wave;
                        n_mcnt = r_mcnt + 32'd1;
                    end else begin
                        n_step = 1'b0;
                        n_mcnt = 32'd0;
                        n_pos  = w_move_pos;
                        n_done = 1'b1;
                    end
                end
            end
            default: n_phase = PH_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEEK1;
            r_hcnt    <= 16'd0;
            r_mcnt    <= 32'd0;
            r_pos     <= POS_MIDDLE;
            r_release <= 32'd0;
            r_step    <= 1'b0;
            r_dir     <= 1'b0;
            r_done    <= 1'b0;
        end else if (i_cmd.exec) begin
            r_phase   <= n_phase;
            r_hcnt    <= n_hcnt;
            r_mcnt    <= n_mcnt;
            r_pos     <= n_pos;
            r_release <= n_release;
            r_step    <= n_step;
            r_dir     <= n_dir;
            r_done    <= n_done;
        end
    end

    // State changes only on a pass, which waits for the output to drain,
    // so the registers themselves hold the pending result.
    assign o_step_level  = r_step;
    assign o_dir_level   = r_dir;
    assign o_move_idle   = r_done;
    assign o_homing_done = (r_phase == PH_DONE);
    assign o_position    = r_pos;

endmodule

// ===== design/shp_ctrl.sv =====
module shp_ctrl
    import shp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_MOD;
            ST_MOD:  if (i_stat.mod_done) n_state = ST_EXEC;
            ST_EXEC: if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        o_cmd.load = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.exec = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);
        priority if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb
    import shp_pkg::*;
;

    localparam int STALL_LIMIT = 4000;   // cycles with no beat before giving up
    localparam int RX_HOLD     = 400;    // long receiver back-pressure stretch
    localparam int SETTLE_GAP  = 8;      // quiet cycles before a register write
    localparam int TAIL_GAP    = 40;     // about one pass latency at the end
    localparam int PRINT_MAX   = 100;    // keep the log short

    // One control-loop pass offered on the input channel
    typedef struct packed {
        logic [31:0] now;
        logic        btn;
        logic [1:0]  cmd;
        logic        hold;   // sender waits for all results before this beat
    } t_pass;

    // Pin and status levels returned for one pass
    typedef struct packed {
        logic       step;
        logic       dir;
        logic       work;
        logic       homed;
        logic [1:0] pos;
    } t_pins;

    // DUT inputs, known from time zero
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic [31:0]       i_now_us       = '0;
    logic              i_button_level = 1'b1;
    logic [1:0]        i_command      = CMD_NONE;
    logic              i_out_ready    = 1'b0;
    logic              psel           = 1'b0;
    logic              penable        = 1'b0;
    logic              pwrite         = 1'b0;
    logic [ADDR_W-1:0] paddr          = '0;
    logic [31:0]       pwdata         = '0;

    logic              o_in_ready;
    logic              o_out_valid;
    logic              o_step_level;
    logic              o_dir_level;
    logic              o_move_idle;
    logic              o_homing_done;
    logic [1:0]        o_position;
    logic [31:0]       prdata;
    logic              pready;

    // Traffic control
    int     tx_idle_pct = 34;
    int     rx_idle_pct = 83;
    logic   hold_req    = 1'b0;
    logic   in_taken    = 1'b0;
    int     err_count   = 0;
    int     quiet_cycles = 0;
    int     hold_left   = 0;
    logic   hold_used   = 1'b0;

    t_pass  passes_pending[$];
    t_pins  pins_due[$];

    // Predicted block state and register copy
    t_cfg        model_cfg = '{RST_STEP_PERIOD, RST_MOVE_COUNT, RST_DEBOUNCE,
                               RST_BACKOFF, RST_SETTLE};
    t_phase      ph      = PH_SEEK1;
    logic [15:0] hcnt    = '0;
    logic [31:0] mcnt    = '0;
    logic [1:0]  pos_r   = POS_MIDDLE;
    logic [31:0] rel_us  = '0;
    logic        step_r  = 1'b0;
    logic        dir_r   = 1'b0;
    logic        done_r  = 1'b0;

    stepper_homing_and_position_control_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_now_us       (i_now_us),
        .i_button_level (i_button_level),
        .i_command      (i_command),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_step_level   (o_step_level),
        .o_dir_level    (o_dir_level),
        .o_move_idle    (o_move_idle),
        .o_homing_done  (o_homing_done),
        .o_position     (o_position),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Step wave: high in the upper half of the period, low for a zero period
    function automatic void drive_pins(input logic dir, input logic [31:0] t);
        logic [31:0] per;
        per = {17'd0, model_cfg.step_period};
        dir_r = dir;
        step_r = (per == 0) ? 1'b0 : ((t % per) > (per >> 1));
    endfunction

    // Debounce: a release stamps the time, a press counts once held long enough
    function automatic logic press_seen(input logic [31:0] t, input logic lvl);
        logic [31:0] held;
        if (lvl) begin
            rel_us = t;
            return 1'b0;
        end
        held = t - rel_us;
        return held > model_cfg.debounce;
    endfunction

    // One pass of a move; the counter is shared by all moves
    function automatic void move_step(input logic dir, input logic [1:0] dest,
                                      input logic [31:0] t);
        if (mcnt < model_cfg.move_count) begin
            done_r = 1'b0;
            drive_pins(dir, t);
            mcnt = mcnt + 32'd1;
        end else begin
            step_r = 1'b0;
            mcnt = '0;
            pos_r = dest;
            done_r = 1'b1;
        end
    endfunction

    // Advance the predicted state by one pass and return the expected levels
    function automatic t_pins predict_pass(input logic [31:0] t, input logic lvl,
                                           input logic [1:0] cmd);
        t_pins r;
        if (ph != PH_DONE) begin
            case (ph)
                PH_SEEK1: begin
                    drive_pins(DIR_DOWN, t);
                    if (press_seen(t, lvl)) ph = PH_BACKOFF;
                end
                PH_BACKOFF: begin
                    if (hcnt < model_cfg.backoff) begin
                        drive_pins(DIR_UP, t);
                        hcnt = hcnt + 16'd1;
                    end else begin
                        drive_pins(DIR_DOWN, t);
                        if (press_seen(t, lvl)) begin
                            ph = PH_SETTLE;
                            hcnt = '0;
                        end
                    end
                end
                PH_SETTLE: begin
                    if (hcnt < model_cfg.settle) begin
                        drive_pins(DIR_UP, t);
                        hcnt = hcnt + 16'd1;
                    end else begin
                        ph = PH_FINISH;
                    end
                end
                default: begin
                    ph = PH_DONE;
                    pos_r = POS_MIDDLE;
                    hcnt = '0;
                end
            endcase
        end else if (cmd == CMD_UP && pos_r != POS_UP) begin
            move_step(DIR_UP, POS_UP, t);
        end else if (cmd == CMD_DOWN && pos_r != POS_DOWN) begin
            move_step(DIR_DOWN, POS_DOWN, t);
        end else if (cmd == CMD_RETURN) begin
            if (pos_r == POS_UP) move_step(DIR_DOWN, POS_MIDDLE, t);
            else if (pos_r == POS_DOWN) move_step(DIR_UP, POS_MIDDLE, t);
        end
        r.step  = step_r;
        r.dir   = dir_r;
        r.work  = done_r;
        r.homed = (ph == PH_DONE);
        r.pos   = pos_r;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        err_count++;
        if (err_count <= PRINT_MAX)
            $display("%0t ns: %s mismatch, expected %0h got %0h", $time, what, want, got);
    endtask

    task automatic add_pass(input logic [31:0] now, input logic btn,
                            input logic [1:0] cmd, input logic hold);
        passes_pending.push_back('{now, btn, cmd, hold});
    endtask

    // Runs of one command with random time and button, complete moves for short counts, some short runs as noise
    task automatic add_random_passes(input int n);
        int made;
        int len;
        int k;
        logic [1:0] cmd;
        made = 0;
        while (made < n) begin
            cmd = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0)
                len = $urandom_range(1, 3);
            else if (model_cfg.move_count < 6)
                len = int'(model_cfg.move_count) + 2;
            else
                len = 6;
            for (k = 0; k < len; k++) begin
                add_pass($urandom(), 1'($urandom_range(0, 1)), cmd,
                         $urandom_range(0, 39) == 0);
                made++;
            end
        end
    endtask

    // APB write: setup then access; the predictor copy follows
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_STEP_PERIOD: model_cfg.step_period = val[14:0];
            REG_MOVE_COUNT:  model_cfg.move_count  = val;
            REG_DEBOUNCE:    model_cfg.debounce    = val;
            REG_BACKOFF:     model_cfg.backoff     = val[15:0];
            REG_SETTLE:      model_cfg.settle      = val[15:0];
            default: ;
        endcase
    endtask

    // Wait until every queued pass has been sent and answered
    task automatic drain();
        while (passes_pending.size() != 0 || i_in_valid || pins_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_GAP) @(negedge i_clk);
    endtask

    // Input driver: one beat at a time, random gaps, optional full pause
    always @(negedge i_clk) begin
        t_pass nxt;
        logic  launch;
        launch = 1'b0;
        if ((!i_in_valid || in_taken) && passes_pending.size() != 0 &&
            $urandom_range(0, 99) >= tx_idle_pct)
            launch = !(passes_pending[0].hold && pins_due.size() != 0);
        if (launch) begin
            nxt = passes_pending.pop_front();
            i_now_us       <= nxt.now;
            i_button_level <= nxt.btn;
            i_command      <= nxt.cmd;
            i_in_valid     <= 1'b1;
        end else if (in_taken) begin
            i_in_valid <= 1'b0;
        end
    end

    // Output ready: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_req && !hold_used) begin
            hold_left = RX_HOLD;
            hold_used = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Monitor: predict on each input beat, check each output beat, watchdog
    always @(posedge i_clk) begin
        t_pins want;
        t_pins got;
        logic  in_fire;
        logic  out_fire;
        in_fire  = i_rst_n && i_in_valid && (o_in_ready === 1'b1);
        out_fire = i_rst_n && (o_out_valid === 1'b1) && i_out_ready;
        in_taken <= in_fire;
        if (in_fire)
            pins_due.push_back(predict_pass(i_now_us, i_button_level, i_command));
        if (out_fire) begin
            got = '{o_step_level, o_dir_level, o_move_idle, o_homing_done, o_position};
            if (pins_due.size() == 0) begin
                report_mismatch("unexpected result", '0, {26'd0, got});
            end else begin
                want = pins_due.pop_front();
                if (got.step !== want.step)
                    report_mismatch("step_level", 32'(want.step), 32'(got.step));
                if (got.dir !== want.dir)
                    report_mismatch("dir_level", 32'(want.dir), 32'(got.dir));
                if (got.work !== want.work)
                    report_mismatch("move_idle", 32'(want.work), 32'(got.work));
                if (got.homed !== want.homed)
                    report_mismatch("homing_done", 32'(want.homed), 32'(got.homed));
                if (got.pos !== want.pos)
                    report_mismatch("position", 32'(want.pos), 32'(got.pos));
            end
        end
        quiet_cycles = (in_fire || out_fire) ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Test sequence
    initial begin
        int i;
        logic [1:0] cmd_seq [13];
        cmd_seq = '{CMD_NONE, CMD_UP, CMD_UP, CMD_UP, CMD_UP, CMD_RETURN, CMD_DOWN,
                    CMD_DOWN, CMD_DOWN, CMD_RETURN, CMD_RETURN, CMD_RETURN, CMD_RETURN};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Short homing: first press across the time wrap, debounce boundary
        cfg_write(REG_STEP_PERIOD, 32'd7);
        cfg_write(REG_MOVE_COUNT, 32'd2);
        cfg_write(REG_DEBOUNCE, 32'd5);
        cfg_write(REG_BACKOFF, 32'd2);
        cfg_write(REG_SETTLE, 32'd1);
        add_pass(32'd100, 1'b1, CMD_UP, 1'b0);
        add_pass(32'd103, 1'b0, CMD_DOWN, 1'b0);
        add_pass(32'hFFFF_FFFE, 1'b1, CMD_RETURN, 1'b0);
        add_pass(32'd3, 1'b0, CMD_NONE, 1'b0);       // held exactly debounce: no press
        add_pass(32'd4, 1'b0, CMD_UP, 1'b0);         // press
        add_pass(32'd10, 1'b0, CMD_NONE, 1'b0);      // back off
        add_pass(32'd11, 1'b1, CMD_DOWN, 1'b0);
        add_pass(32'd20, 1'b1, CMD_NONE, 1'b0);      // seek again, release stamped
        drain();

        // Zero debounce: same time is no press, one later is
        cfg_write(REG_DEBOUNCE, 32'd0);
        add_pass(32'd20, 1'b0, CMD_UP, 1'b0);
        add_pass(32'd21, 1'b0, CMD_NONE, 1'b0);
        add_pass(32'd22, 1'b1, CMD_NONE, 1'b0);      // settle
        add_pass(32'd23, 1'b1, CMD_DOWN, 1'b0);      // settle used up, pins held
        add_pass(32'd24, 1'b0, CMD_NONE, 1'b0);      // homing finishes
        drain();

        // Every command, no-effect cases, command change in the middle of a move
        for (i = 0; i < 13; i++)
            add_pass(32'd1000 + 32'(3 * i), i[0], cmd_seq[i], 1'b0);
        drain();

        // Sender gaps, heavy receiver stalls, one long hold-off
        cfg_write(REG_STEP_PERIOD, 32'd2);
        cfg_write(REG_MOVE_COUNT, 32'd3);
        cfg_write(REG_DEBOUNCE, 32'hFFFF_FFFF);
        cfg_write(REG_BACKOFF, 32'd65535);
        cfg_write(REG_SETTLE, 32'd0);
        hold_req <= 1'b1;
        add_random_passes(150);
        drain();

        // Heavy sender gaps, light stalls, instant moves
        tx_idle_pct <= 83;
        rx_idle_pct <= 34;
        cfg_write(REG_STEP_PERIOD, 32'd32767);
        cfg_write(REG_MOVE_COUNT, 32'd0);
        cfg_write(REG_BACKOFF, 32'd0);
        cfg_write(REG_SETTLE, 32'd65535);
        add_random_passes(150);
        drain();

        // Back to back from here on
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        cfg_write(REG_STEP_PERIOD, $urandom_range(2, 32767));
        cfg_write(REG_MOVE_COUNT, 32'd1);
        add_random_passes(150);
        drain();

        // Zero period and a move that never ends
        cfg_write(REG_STEP_PERIOD, 32'd0);
        cfg_write(REG_MOVE_COUNT, 32'hFFFF_FFFF);
        add_random_passes(60);
        drain();

        // Shorter count than the shared counter left behind
        cfg_write(REG_STEP_PERIOD, 32'd1000);
        cfg_write(REG_MOVE_COUNT, 32'd2);
        add_random_passes(130);
        drain();

        repeat (TAIL_GAP) @(negedge i_clk);
        if (err_count == 0 && pins_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
design/shp_pkg.sv
design/shp_regs.sv
design/shp_mod.sv
design/shp_dp.sv
design/shp_ctrl.sv
design/stepper_homing_and_position_control_unit.sv
dv/tb.sv
